### src/pqtm_pkg.sv
// pqtm_pkg: shared types and constants for the parallax quad texture mapper.
// Used by every module in src; depends on nothing.
package pqtm_pkg;

    localparam logic [1:0] OP_LOAD_TEXEL  = 2'd0;
    localparam logic [1:0] OP_LOAD_HEIGHT = 2'd1;
    localparam logic [1:0] OP_DRAW        = 2'd2;

    localparam logic CFG_VIEW_X = 1'b0;
    localparam logic CFG_VIEW_Y = 1'b1;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_CW    = 4;
    localparam int FLIGHT_W   = 3;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] load_address;
        logic [7:0]  load_byte;
        logic [15:0] u_top_left;
        logic [15:0] v_top_left;
        logic [15:0] u_top_right;
        logic [15:0] v_top_right;
        logic [15:0] u_bottom_left;
        logic [15:0] v_bottom_left;
        logic [15:0] u_bottom_right;
        logic [15:0] v_bottom_right;
    } t_in;

    typedef struct packed {
        logic [15:0] pixel_pair;
        logic [2:0]  row_index;
        logic [2:0]  pair_index;
        logic        last_pair;
    } t_out;

    typedef struct packed {
        logic [31:0] uva;
        logic [31:0] uvb;
        logic [2:0]  row_index;
        logic [2:0]  pair_index;
        logic        last_pair;
    } t_issue;

    // packed UUuuVVvv coordinate to map address
    function automatic logic [15:0] map_addr(input logic [31:0] c);
        return {c[15:8], c[31:24]};
    endfunction

endpackage

### src/parallax_quad_texture_mapper_unit.sv
// parallax_quad_texture_mapper_unit: top level, config registers, handshakes.
// Depends on pqtm_pkg, pqtm_walker, pqtm_fetch, pqtm_fifo.
//
//  channel | signals                          | payload
//  in      | i_in_valid / o_in_ready          | t_in  i_in
//  out     | o_out_valid / i_out_ready        | t_out o_out
//  cfg     | i_cfg_we, i_cfg_index, i_cfg_data| 16-bit view step
//
// Each load beat is written to its memory as it is accepted. A draw issues one
// pixel pair per cycle while credit allows, QUAD_HEIGHT * (QUAD_WIDTH / 2)
// beats (64 at defaults), through a pipeline: height read, multiply, offset
// add, dual texel read, queue. Input is accepted again once the walker is idle
// and the last pair has left the pipeline.
// Reset is synchronous; no clearing pass, memories hold whatever is loaded.
// Output stalls fill the 8-beat queue, and issue stops by credit.
module parallax_quad_texture_mapper_unit import pqtm_pkg::*; #(
    parameter int QUAD_WIDTH  = 16,
    parameter int QUAD_HEIGHT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic signed [15:0]  r_view_x, r_view_y;
    logic                accept, start, busy, issue_valid, push, grant;
    t_issue              issue;
    t_out                push_data;
    logic [FLIGHT_W-1:0] inflight;
    logic [FIFO_CW-1:0]  fifo_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x <= '0;
            r_view_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VIEW_X: r_view_x <= i_cfg_data;
                CFG_VIEW_Y: r_view_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = !busy && (inflight == '0);
    assign accept     = i_in_valid && o_in_ready;
    assign start      = accept && (i_in.op == OP_DRAW);
    assign grant      = (5'(fifo_count) + 5'(inflight)) < 5'(FIFO_DEPTH);

    pqtm_walker #(
        .QUAD_WIDTH  (QUAD_WIDTH),
        .QUAD_HEIGHT (QUAD_HEIGHT)
    ) u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_quad        (i_in),
        .i_grant       (grant),
        .o_busy        (busy),
        .o_issue_valid (issue_valid),
        .o_issue       (issue)
    );

    pqtm_fetch u_fetch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_texel    (accept && (i_in.op == OP_LOAD_TEXEL)),
        .i_wr_height   (accept && (i_in.op == OP_LOAD_HEIGHT)),
        .i_wr_addr     (i_in.load_address),
        .i_wr_byte     (i_in.load_byte),
        .i_view_x      (r_view_x),
        .i_view_y      (r_view_y),
        .i_issue_valid (issue_valid),
        .i_issue       (issue),
        .o_inflight    (inflight),
        .o_push        (push),
        .o_push_data   (push_data)
    );

    pqtm_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (i_out_ready),
        .o_valid     (o_out_valid),
        .o_data      (o_out),
        .o_count     (fifo_count)
    );

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (5'(fifo_count) + 5'(inflight)) <= 5'(FIFO_DEPTH))
        else $error("queue credit exceeded");

    a_draw_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> busy)
        else $error("draw accepted but walker idle");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && (inflight == '0)) |=> (inflight == '0))
        else $error("pair in flight without a draw");

    a_no_push_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !(o_out_valid && i_out_ready)) |-> (fifo_count < FIFO_CW'(FIFO_DEPTH)))
        else $error("push into full queue");

endmodule

### src/pqtm_walker.sv
// pqtm_walker: quad setup and coordinate stepping, one pixel pair per grant.
// Depends on pqtm_pkg.
module pqtm_walker import pqtm_pkg::*; #(
    parameter int QUAD_WIDTH  = 16,
    parameter int QUAD_HEIGHT = 8
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_in    i_quad,
    input  logic   i_grant,
    output logic   o_busy,
    output logic   o_issue_valid,
    output t_issue o_issue
);

    localparam int PAIRS  = QUAD_WIDTH / 2;
    localparam int ROWS   = QUAD_HEIGHT;
    localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LOG_W  = $clog2(QUAD_WIDTH + 1) - 1;
    localparam int LOG_H  = $clog2(QUAD_HEIGHT + 1) - 1;
    localparam logic [PAIR_W-1:0] LAST_PAIR = PAIR_W'(PAIRS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

    function automatic logic signed [31:0] diff(input logic [15:0] a, input logic [15:0] b);
        return {16'b0, a} - {16'b0, b};
    endfunction

    function automatic logic [15:0] asr16(input logic signed [31:0] d, input int sh);
        logic signed [31:0] t;
        t = d >>> sh;
        return t[15:0];
    endfunction

    logic              r_busy;
    logic [31:0]       r_left, r_left_step, r_xstep, r_xstep_d, r_uv;
    logic [ROW_W-1:0]  r_row;
    logic [PAIR_W-1:0] r_pair;

    logic signed [31:0] du_t, dv_t, du_b, dv_b, dl_u, dl_v, ddu, ddv;
    logic [31:0]        s_left, s_left_step, s_xstep, s_xstep_d;
    logic [31:0]        uvb, next_left;
    logic               issue, row_end, quad_end;

    always_comb begin
        du_t = diff(i_quad.u_top_right, i_quad.u_top_left);
        dv_t = diff(i_quad.v_top_right, i_quad.v_top_left);
        du_b = diff(i_quad.u_bottom_right, i_quad.u_bottom_left);
        dv_b = diff(i_quad.v_bottom_right, i_quad.v_bottom_left);
        dl_u = diff(i_quad.u_bottom_left, i_quad.u_top_left);
        dl_v = diff(i_quad.v_bottom_left, i_quad.v_top_left);
        ddu  = (du_b - du_t) >>> LOG_H;
        ddv  = (dv_b - dv_t) >>> LOG_H;
        s_left      = {i_quad.u_top_left, i_quad.v_top_left};
        s_left_step = {asr16(dl_u, LOG_H), asr16(dl_v, LOG_H)};
        s_xstep     = {asr16(du_t, LOG_W), asr16(dv_t, LOG_W)};
        s_xstep_d   = {asr16(ddu, LOG_W), asr16(ddv, LOG_W)};
    end

    assign issue     = r_busy & i_grant;
    assign uvb       = r_uv + r_xstep;
    assign next_left = r_left + r_left_step;
    assign row_end   = (r_pair == LAST_PAIR);
    assign quad_end  = row_end && (r_row == LAST_ROW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_row  <= '0;
            r_pair <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_row  <= '0;
            r_pair <= '0;
        end else if (issue) begin
            if (quad_end) begin
                r_busy <= 1'b0;
            end
            if (row_end) begin
                r_pair <= '0;
                r_row  <= r_row + ROW_W'(1);
            end else begin
                r_pair <= r_pair + PAIR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_left      <= s_left;
            r_uv        <= s_left;
            r_left_step <= s_left_step;
            r_xstep     <= s_xstep;
            r_xstep_d   <= s_xstep_d;
        end else if (issue) begin
            if (row_end) begin
                r_left  <= next_left;
                r_uv    <= next_left;
                r_xstep <= r_xstep + r_xstep_d;
            end else begin
                r_uv <= uvb + r_xstep;
            end
        end
    end

    assign o_busy             = r_busy;
    assign o_issue_valid      = issue;
    assign o_issue.uva        = r_uv;
    assign o_issue.uvb        = uvb;
    assign o_issue.row_index  = 3'(32'(r_row));
    assign o_issue.pair_index = 3'(32'(r_pair));
    assign o_issue.last_pair  = quad_end;

endmodule

### src/pqtm_fetch.sv
// pqtm_fetch: height and texel memories, parallax offset and texel fetch pipeline.
// Depends on pqtm_pkg.
module pqtm_fetch import pqtm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_texel,
    input  logic                i_wr_height,
    input  logic [15:0]         i_wr_addr,
    input  logic [7:0]          i_wr_byte,
    input  logic signed [15:0]  i_view_x,
    input  logic signed [15:0]  i_view_y,
    input  logic                i_issue_valid,
    input  t_issue              i_issue,
    output logic [FLIGHT_W-1:0] o_inflight,
    output logic                o_push,
    output t_out                o_push_data
);

    logic [7:0] r_texel_mem  [65536];
    logic [7:0] r_height_mem [65536];

    logic        r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    t_issue      r_s1, r_s2, r_s3;
    logic [2:0]  r_s4_row, r_s4_pair;
    logic        r_s4_last;
    logic [7:0]  r_h, r_ta, r_tb;
    logic [31:0] r_s2_pv, r_s3_off;
    logic [15:0] r_s2_px;

    logic signed [24:0] pv_raw;
    logic [15:0]        px;
    logic [31:0]        uv2a, uv2b;

    // height read
    always_ff @(posedge i_clk) begin
        if (i_wr_height) begin
            r_height_mem[i_wr_addr] <= i_wr_byte;
        end
        r_h <= r_height_mem[map_addr(i_issue.uva)];
    end

    assign pv_raw = i_view_y * $signed({1'b0, r_h});
    assign px     = 16'($unsigned(i_view_x) * {8'b0, r_h});
    assign uv2a   = r_s3.uva + r_s3_off;
    assign uv2b   = r_s3.uvb + r_s3_off;

    // texel reads, two ports
    always_ff @(posedge i_clk) begin
        if (i_wr_texel) begin
            r_texel_mem[i_wr_addr] <= i_wr_byte;
        end
        r_ta <= r_texel_mem[map_addr(uv2a)];
        r_tb <= r_texel_mem[map_addr(uv2b)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= i_issue_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1      <= i_issue;
        r_s2      <= r_s1;
        r_s2_pv   <= 32'(pv_raw);
        r_s2_px   <= px;
        r_s3      <= r_s2;
        r_s3_off  <= r_s2_pv + {r_s2_px, 16'h0000};
        r_s4_row  <= r_s3.row_index;
        r_s4_pair <= r_s3.pair_index;
        r_s4_last <= r_s3.last_pair;
    end

    assign o_inflight = FLIGHT_W'($countones({r_s1_v, r_s2_v, r_s3_v, r_s4_v}));
    assign o_push     = r_s4_v;
    assign o_push_data.pixel_pair = {r_tb, r_ta};
    assign o_push_data.row_index  = r_s4_row;
    assign o_push_data.pair_index = r_s4_pair;
    assign o_push_data.last_pair  = r_s4_last;

endmodule

### src/pqtm_fifo.sv
// pqtm_fifo: result queue between the fetch pipeline and the output channel.
// Depends on pqtm_pkg.
module pqtm_fifo import pqtm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  t_out               i_push_data,
    input  logic               i_pop,
    output logic               o_valid,
    output t_out               o_data,
    output logic [FIFO_CW-1:0] o_count
);

    t_out               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               pop;

    assign pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (i_push && !pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (pop && !i_push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule
